### rtl/bse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bse_pkg
// Shared widths, register map, curve segments and stage structs for the
// battery state-of-charge estimator.
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int ADC_BITS    = 12;
    localparam int SAMPLES     = 8;
    localparam int SUM_W       = ADC_BITS + $clog2(SAMPLES);
    localparam int CNT_W       = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int K_W         = 24;
    localparam int MV_W        = 16;
    localparam int PCT_W       = 7;
    localparam int SHIFT       = 16 + $clog2(SAMPLES);
    localparam int PROD_W      = SUM_W + K_W;
    localparam int MVF_W       = PROD_W - SHIFT;

    localparam int APB_DW      = 32;
    localparam int APB_AW      = 3;
    localparam logic REG_K     = 1'b0;
    localparam logic REG_WARN  = 1'b1;

    localparam logic [K_W-1:0]  K_RESET    = 24'd211250;
    localparam logic [MV_W-1:0] WARN_RESET = 16'd11100;

    localparam logic [MV_W-1:0] MV_FULL  = 16'd12600;
    localparam logic [MV_W-1:0] MV_EMPTY = 16'd9000;
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    localparam int SEGS        = 7;
    localparam int SEG_W       = 3;
    localparam int D_W         = 11;
    localparam int DPCT_W      = 5;
    localparam int WID_W       = 11;
    localparam int X_W         = 16;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 18;
    localparam int RP_W        = X_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_600  = RECIP_W'((2**RECIP_SHIFT + 599) / 600);
    localparam logic [RECIP_W-1:0] RECIP_300  = RECIP_W'((2**RECIP_SHIFT + 299) / 300);
    localparam logic [RECIP_W-1:0] RECIP_1500 = RECIP_W'((2**RECIP_SHIFT + 1499) / 1500);

    typedef struct packed {
        logic [MV_W-1:0]    hi;
        logic [MV_W-1:0]    lo;
        logic [PCT_W-1:0]   pct;
        logic [DPCT_W-1:0]  dpct;
        logic [WID_W-1:0]   width;
        logic [RECIP_W-1:0] recip;
    } seg_t;

    typedef struct packed {
        logic [K_W-1:0]  k;
        logic [MV_W-1:0] warn;
    } cfg_t;

    typedef struct packed {
        logic [MV_W-1:0] mv;
        logic            low;
    } scale_t;

    function automatic seg_t seg_info(input logic [SEG_W-1:0] idx);
        seg_t s;
        case (idx)
            3'd0:    s = '{16'd12600, 16'd12000, 7'd100, 5'd10, 11'd600,  RECIP_600};
            3'd1:    s = '{16'd12000, 16'd11700, 7'd90,  5'd15, 11'd300,  RECIP_300};
            3'd2:    s = '{16'd11700, 16'd11400, 7'd75,  5'd15, 11'd300,  RECIP_300};
            3'd3:    s = '{16'd11400, 16'd11100, 7'd60,  5'd20, 11'd300,  RECIP_300};
            3'd4:    s = '{16'd11100, 16'd10800, 7'd40,  5'd20, 11'd300,  RECIP_300};
            3'd5:    s = '{16'd10800, 16'd10500, 7'd20,  5'd10, 11'd300,  RECIP_300};
            3'd6:    s = '{16'd10500, 16'd9000,  7'd10,  5'd10, 11'd1500, RECIP_1500};
            default: s = '{16'd9000,  16'd9000,  7'd0,   5'd0,  11'd1,    RECIP_1500};
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

### rtl/bse_apb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bse_apb_regs
// APB register file: conversion gain and low-battery threshold.
// ----------------------------------------------------------------------------
module bse_apb_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [bse_pkg::APB_AW-1:0]  paddr,
    input  wire logic [bse_pkg::APB_DW-1:0]  pwdata,
    output logic      [bse_pkg::APB_DW-1:0]  prdata,
    output logic                             pready,
    output bse_pkg::cfg_t                    cfg
);
    import bse_pkg::*;

    logic [K_W-1:0]  k_reg,    k_next;
    logic [MV_W-1:0] warn_reg, warn_next;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb begin
        k_next    = k_reg;
        warn_next = warn_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_K:    k_next    = pwdata[K_W-1:0];
                REG_WARN: warn_next = pwdata[MV_W-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_K:    prdata = APB_DW'(k_reg);
            REG_WARN: prdata = APB_DW'(warn_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg    <= K_RESET;
            warn_reg <= WARN_RESET;
        end else begin
            k_reg    <= k_next;
            warn_reg <= warn_next;
        end
    end

    assign cfg.k    = k_reg;
    assign cfg.warn = warn_reg;

endmodule
`default_nettype wire

### rtl/bse_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bse_accum
// Sample accumulator; hands the completed block sum to the scaling stage.
// ----------------------------------------------------------------------------
module bse_accum (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    input  wire logic [bse_pkg::ADC_BITS-1:0]  in_sample,
    output logic                               in_ready,
    output logic                               out_valid,
    output logic      [bse_pkg::SUM_W-1:0]     out_sum,
    input  wire logic                          out_ready,
    output logic      [bse_pkg::CNT_W-1:0]     count
);
    import bse_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

    logic [SUM_W-1:0] sum_reg,   sum_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             valid_reg, valid_next;
    logic [SUM_W-1:0] bsum_reg,  bsum_next;
    logic [SUM_W-1:0] sum_add;
    logic             accept;
    logic             last;

    assign in_ready = !valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign last     = (cnt_reg == CNT_LAST);
    assign sum_add  = sum_reg + SUM_W'(in_sample);

    always_comb begin
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg;
        bsum_next  = bsum_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (accept) begin
            if (last) begin
                sum_next   = '0;
                cnt_next   = '0;
                valid_next = 1'b1;
                bsum_next  = sum_add;
            end else begin
                sum_next = sum_add;
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bsum_reg <= bsum_next;
    end

    assign out_valid = valid_reg;
    assign out_sum   = bsum_reg;
    assign count     = cnt_reg;

endmodule
`default_nettype wire

### rtl/bse_scale.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bse_scale
// Sum to millivolts: gain multiply, block-average shift, saturation, low flag.
// ----------------------------------------------------------------------------
module bse_scale (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire bse_pkg::cfg_t             cfg,
    input  wire logic                      in_valid,
    input  wire logic [bse_pkg::SUM_W-1:0] in_sum,
    output logic                           in_ready,
    output logic                           out_valid,
    output bse_pkg::scale_t                out_data,
    input  wire logic                      out_ready
);
    import bse_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [MVF_W-1:0]  mv_full;
    logic [MV_W-1:0]   mv_sat;
    logic              valid_reg, valid_next;
    scale_t            data_reg,  data_next;

    assign prod    = PROD_W'(in_sum) * PROD_W'(cfg.k);
    assign mv_full = MVF_W'(prod >> SHIFT);
    assign mv_sat  = (mv_full > MVF_W'({MV_W{1'b1}})) ? {MV_W{1'b1}} : mv_full[MV_W-1:0];

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (in_ready) begin
            valid_next = in_valid;
            if (in_valid) begin
                data_next.mv  = mv_sat;
                data_next.low = (mv_sat <= cfg.warn);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

### rtl/bse_curve.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bse_curve
// Piecewise-linear state of charge: segment select and numerator, then a
// reciprocal-multiply ceiling divide into the output register.
// ----------------------------------------------------------------------------
module bse_curve (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    input  wire bse_pkg::scale_t             in_data,
    output logic                             in_ready,
    output logic                             out_valid,
    output logic      [bse_pkg::MV_W-1:0]    out_mv,
    output logic      [bse_pkg::PCT_W-1:0]   out_pct,
    output logic                             out_low,
    input  wire logic                        out_ready
);
    import bse_pkg::*;

    // segment stage
    logic             d_valid_reg, d_valid_next;
    scale_t           d_data_reg,  d_data_next;
    logic             d_full_reg,  d_full_next;
    logic             d_empty_reg, d_empty_next;
    logic [SEG_W-1:0] d_seg_reg,   d_seg_next;
    logic [X_W-1:0]   d_x_reg,     d_x_next;
    logic             d_ready;

    // output stage
    logic             m_valid_reg, m_valid_next;
    logic [MV_W-1:0]  m_mv_reg,    m_mv_next;
    logic [PCT_W-1:0] m_pct_reg,   m_pct_next;
    logic             m_low_reg,   m_low_next;

    logic [SEG_W-1:0] seg;
    seg_t             sc;
    seg_t             sd;
    logic [D_W-1:0]   gap;
    logic [X_W-1:0]   x;
    logic [RP_W-1:0]  rp;
    logic [PCT_W-1:0] drop;
    logic [PCT_W-1:0] pct;

    always_comb begin
        seg = SEG_W'(SEGS - 1);
        for (int i = SEGS - 1; i >= 0; i--) begin
            if (in_data.mv > seg_info(SEG_W'(i)).lo) begin
                seg = SEG_W'(i);
            end
        end
    end

    assign sc   = seg_info(seg);
    assign gap  = D_W'(sc.hi - in_data.mv);
    assign x    = X_W'(gap) * X_W'(sc.dpct) + X_W'(sc.width) - X_W'(1);

    assign m_valid_next = out_ready ? d_valid_reg : m_valid_reg;
    assign d_ready      = !m_valid_reg || out_ready;
    assign in_ready     = !d_valid_reg || d_ready;

    always_comb begin
        d_valid_next = d_valid_reg;
        d_data_next  = d_data_reg;
        d_full_next  = d_full_reg;
        d_empty_next = d_empty_reg;
        d_seg_next   = d_seg_reg;
        d_x_next     = d_x_reg;
        if (in_ready) begin
            d_valid_next = in_valid;
            if (in_valid) begin
                d_data_next  = in_data;
                d_full_next  = (in_data.mv >= MV_FULL);
                d_empty_next = (in_data.mv <= MV_EMPTY);
                d_seg_next   = seg;
                d_x_next     = x;
            end
        end
    end

    assign sd   = seg_info(d_seg_reg);
    assign rp   = RP_W'(d_x_reg) * RP_W'(sd.recip);
    assign drop = PCT_W'(rp >> RECIP_SHIFT);

    always_comb begin
        if (d_full_reg) begin
            pct = PCT_FULL;
        end else if (d_empty_reg) begin
            pct = PCT_EMPTY;
        end else begin
            pct = sd.pct - drop;
        end
    end

    always_comb begin
        m_mv_next  = m_mv_reg;
        m_pct_next = m_pct_reg;
        m_low_next = m_low_reg;
        if (d_ready && d_valid_reg) begin
            m_mv_next  = d_data_reg.mv;
            m_pct_next = pct;
            m_low_next = d_data_reg.low;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            d_valid_reg <= d_valid_next;
            m_valid_reg <= d_ready ? d_valid_reg : m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        d_data_reg  <= d_data_next;
        d_full_reg  <= d_full_next;
        d_empty_reg <= d_empty_next;
        d_seg_reg   <= d_seg_next;
        d_x_reg     <= d_x_next;
        m_mv_reg    <= m_mv_next;
        m_pct_reg   <= m_pct_next;
        m_low_reg   <= m_low_next;
    end

    assign out_valid = m_valid_reg;
    assign out_mv    = m_mv_reg;
    assign out_pct   = m_pct_reg;
    assign out_low   = m_low_reg;

endmodule
`default_nettype wire

### rtl/battery_soc_estimator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// battery_soc_estimator_top
// Averages blocks of ADC samples into battery millivolts, state of charge
// and a low-battery flag.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle unless stalled; one result per 8-sample block.
// Path: after the transfer of the last sample of a block, the result passes the
//   accumulate, scale multiply, segment and divide stage registers.
// Reset: synchronous, active low; clears the running sum, the sample count,
//   all stage valids and loads the register defaults.
// ----------------------------------------------------------------------------
module battery_soc_estimator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] adc_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // [15:0] battery_mv, [22:16] percent, [23] is_low
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import bse_pkg::*;

    cfg_t             cfg;
    logic             b_valid;
    logic [SUM_W-1:0] b_sum;
    logic             b_ready;
    logic             c_valid;
    scale_t           c_data;
    logic             c_ready;
    logic [CNT_W-1:0] count;
    logic [MV_W-1:0]  out_mv;
    logic [PCT_W-1:0] out_pct;
    logic             out_low;

    bse_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bse_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_sample (s_tdata[ADC_BITS-1:0]),
        .in_ready  (s_tready),
        .out_valid (b_valid),
        .out_sum   (b_sum),
        .out_ready (b_ready),
        .count     (count)
    );

    bse_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (b_valid),
        .in_sum    (b_sum),
        .in_ready  (b_ready),
        .out_valid (c_valid),
        .out_data  (c_data),
        .out_ready (c_ready)
    );

    bse_curve u_curve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_data   (c_data),
        .in_ready  (c_ready),
        .out_valid (m_tvalid),
        .out_mv    (out_mv),
        .out_pct   (out_pct),
        .out_low   (out_low),
        .out_ready (m_tready)
    );

    assign m_tdata = {out_low, out_pct, out_mv};

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count) < SAMPLES)
        else $error("sample count out of range");

    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_pct <= PCT_FULL))
        else $error("percent above full scale");

    a_pct_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((out_mv >= MV_FULL) ? (out_pct == PCT_FULL) :
                      (out_mv <= MV_EMPTY) ? (out_pct == PCT_EMPTY) :
                      (out_pct != PCT_FULL))
        )
        else $error("percent inconsistent with curve end points");

    a_low_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_low == (out_mv <= cfg.warn)))
        else $error("low flag does not match threshold");

endmodule
`default_nettype wire
